// File: hw/rtl/tpb_pkg.sv
// Shared types and constants for the point-in-triangle barycentric core.
package tpb_pkg;

    localparam int unsigned WEIGHT_BITS = 32;
    localparam int unsigned TOL_BITS    = 16;

    typedef struct packed {
        logic hit;
        logic degen;
    } tpb_flags_t;

endpackage

// File: hw/rtl/tpb_front.sv
// Front end: coordinate differences, cross products, edge tests and magnitudes.
module tpb_front #(
    parameter int CB = 16,
    parameter int SW = 2 * (CB + 1) + 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [CB-1:0]                     v0_x,
    input  logic [CB-1:0]                     v0_y,
    input  logic [CB-1:0]                     v1_x,
    input  logic [CB-1:0]                     v1_y,
    input  logic [CB-1:0]                     v2_x,
    input  logic [CB-1:0]                     v2_y,
    input  logic [CB-1:0]                     point_x,
    input  logic [CB-1:0]                     point_y,
    input  logic [tpb_pkg::TOL_BITS-1:0]      tol,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [SW-1:0]                     n0_mag,
    output logic [SW-1:0]                     n1_mag,
    output logic [SW-1:0]                     d_mag,
    output logic                              neg0,
    output logic                              neg1,
    output tpb_pkg::tpb_flags_t               flags
);

    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;
    localparam int TW = SW + 1;

    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [DW-1:0] x0, y0, x1, y1, x2, y2, px, py;

    // Stage 1: differences.
    logic signed [DW-1:0] ea_reg [3];
    logic signed [DW-1:0] eb_reg [3];
    logic signed [DW-1:0] ec_reg [3];
    logic signed [DW-1:0] ed_reg [3];
    logic signed [DW-1:0] ax_reg, ay_reg, bx_reg, by_reg, qx_reg, qy_reg;
    logic                 coinc1_reg;

    // Stage 2: products.
    logic signed [PW-1:0] ep_reg [3];
    logic signed [PW-1:0] eq_reg [3];
    logic signed [PW-1:0] c_a_reg, c_b_reg, n0_a_reg, n0_b_reg, n1_a_reg, n1_b_reg;
    logic                 coinc2_reg;

    // Stage 3: sums.
    logic signed [SW-1:0] dot_reg [3];
    logic signed [SW-1:0] c_reg, n0_reg, n1_reg;
    logic                 coinc3_reg;

    // Stage 4: edge decisions and magnitudes.
    logic [SW-1:0]        n0m_reg, n1m_reg, dm_reg;
    logic                 neg0_reg, neg1_reg;
    tpb_pkg::tpb_flags_t  flags_reg;

    logic signed [TW-1:0] tol_ext;
    logic [2:0]           edge_ok;

    assign en4 = ~v4_reg | out_ready;
    assign en3 = ~v3_reg | en4;
    assign en2 = ~v2_reg | en3;
    assign en1 = ~v1_reg | en2;
    assign in_ready = en1;

    assign x0 = {v0_x[CB-1], v0_x};
    assign y0 = {v0_y[CB-1], v0_y};
    assign x1 = {v1_x[CB-1], v1_x};
    assign y1 = {v1_y[CB-1], v1_y};
    assign x2 = {v2_x[CB-1], v2_x};
    assign y2 = {v2_y[CB-1], v2_y};
    assign px = {point_x[CB-1], point_x};
    assign py = {point_y[CB-1], point_y};

    assign tol_ext = $signed({{(TW - tpb_pkg::TOL_BITS){1'b0}}, tol});

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            edge_ok[k] = ~(TW'(dot_reg[k]) + tol_ext < 0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ea_reg[0] <= px - x0;  eb_reg[0] <= y0 - y1;
            ec_reg[0] <= py - y0;  ed_reg[0] <= x1 - x0;
            ea_reg[1] <= px - x1;  eb_reg[1] <= y1 - y2;
            ec_reg[1] <= py - y1;  ed_reg[1] <= x2 - x1;
            ea_reg[2] <= px - x2;  eb_reg[2] <= y2 - y0;
            ec_reg[2] <= py - y2;  ed_reg[2] <= x0 - x2;
            ax_reg <= x0 - x2;
            ay_reg <= y0 - y2;
            bx_reg <= x1 - x2;
            by_reg <= y1 - y2;
            qx_reg <= px - x2;
            qy_reg <= py - y2;
            coinc1_reg <= (x1 == x0) && (y1 == y0) && (x2 == x0) && (y2 == y0);
        end
        if (en2)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ep_reg[k] <= PW'(ea_reg[k]) * PW'(eb_reg[k]);
                eq_reg[k] <= PW'(ec_reg[k]) * PW'(ed_reg[k]);
            end
            c_a_reg  <= PW'(ax_reg) * PW'(by_reg);
            c_b_reg  <= PW'(ay_reg) * PW'(bx_reg);
            n0_a_reg <= PW'(qx_reg) * PW'(by_reg);
            n0_b_reg <= PW'(qy_reg) * PW'(bx_reg);
            n1_a_reg <= PW'(ax_reg) * PW'(qy_reg);
            n1_b_reg <= PW'(ay_reg) * PW'(qx_reg);
            coinc2_reg <= coinc1_reg;
        end
        if (en3)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dot_reg[k] <= SW'(ep_reg[k]) + SW'(eq_reg[k]);
            end
            c_reg  <= SW'(c_a_reg) - SW'(c_b_reg);
            n0_reg <= SW'(n0_a_reg) - SW'(n0_b_reg);
            n1_reg <= SW'(n1_a_reg) - SW'(n1_b_reg);
            coinc3_reg <= coinc2_reg;
        end
        if (en4)
        begin
            flags_reg.hit    <= ~coinc3_reg & (&edge_ok);
            flags_reg.degen  <= (c_reg == '0);
            neg0_reg <= n0_reg[SW-1] ^ c_reg[SW-1];
            neg1_reg <= n1_reg[SW-1] ^ c_reg[SW-1];
            n0m_reg  <= n0_reg[SW-1] ? SW'(-n0_reg) : SW'(n0_reg);
            n1m_reg  <= n1_reg[SW-1] ? SW'(-n1_reg) : SW'(n1_reg);
            dm_reg   <= c_reg[SW-1] ? SW'(-c_reg) : SW'(c_reg);
        end
    end

    assign out_valid = v4_reg;
    assign n0_mag    = n0m_reg;
    assign n1_mag    = n1m_reg;
    assign d_mag     = dm_reg;
    assign neg0      = neg0_reg;
    assign neg1      = neg1_reg;
    assign flags     = flags_reg;

endmodule

// File: hw/rtl/tpb_div.sv
// Two-lane restoring divider: an entry stage, then one quotient bit per pipeline stage.
module tpb_div #(
    parameter int SW   = 35,
    parameter int FRAC = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [SW-1:0]                n0_mag,
    input  logic [SW-1:0]                n1_mag,
    input  logic [SW-1:0]                d_mag,
    input  logic                         neg0,
    input  logic                         neg1,
    input  tpb_pkg::tpb_flags_t          flags_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   ovf,
    output logic [1:0]                   neg,
    output logic [tpb_pkg::WEIGHT_BITS-1:0] q0,
    output logic [tpb_pkg::WEIGHT_BITS-1:0] q1,
    output tpb_pkg::tpb_flags_t          flags_out
);

    localparam int QB = tpb_pkg::WEIGHT_BITS;
    localparam int LS = QB - FRAC;
    localparam int NS = QB + 1;

    typedef struct packed {
        logic          ovf;
        logic          neg;
        logic [SW-1:0] nm;
        logic [SW-1:0] rem;
        logic [QB-1:0] q;
    } lane_t;

    typedef struct packed {
        lane_t [1:0]         ln;
        logic [SW-1:0]       dm;
        tpb_pkg::tpb_flags_t flags;
    } stage_t;

    stage_t     st_reg [NS];
    stage_t     st_next [NS];
    logic          v_reg [NS];
    logic [NS:0]   en;

    logic [SW+LS-1:0] nm_wide [2];
    logic [SW+LS-1:0] dm_wide;
    logic [SW-1:0]    nm_in [2];
    logic             neg_in [2];

    assign en[NS]   = out_ready;
    assign in_ready = en[0];

    assign nm_in[0]  = n0_mag;
    assign nm_in[1]  = n1_mag;
    assign neg_in[0] = neg0;
    assign neg_in[1] = neg1;
    assign dm_wide   = {d_mag, {LS{1'b0}}};

    // Entry stage: overflow test and initial partial remainder.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            nm_wide[l] = {{LS{1'b0}}, nm_in[l]};
            st_next[0].ln[l].ovf = (nm_wide[l] >= dm_wide);
            st_next[0].ln[l].neg = neg_in[l];
            st_next[0].ln[l].nm  = nm_in[l];
            st_next[0].ln[l].rem = SW'(nm_wide[l] >> LS);
            st_next[0].ln[l].q   = '0;
        end
        st_next[0].dm    = d_mag;
        st_next[0].flags = flags_in;
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        assign en[k] = ~v_reg[k] | en[k+1];

        if (k > 0)
        begin : g_step
            localparam int QI = QB - k;
            logic         nbit [2];
            logic [SW:0]  trial [2];
            logic         take [2];
            lane_t        ln_next [2];

            for (genvar l = 0; l < 2; l++)
            begin : g_lane
                if (QI >= FRAC && QI - FRAC < SW)
                begin : g_bit
                    assign nbit[l] = st_reg[k-1].ln[l].nm[QI-FRAC];
                end
                else
                begin : g_zero
                    assign nbit[l] = 1'b0;
                end

                assign trial[l] = {st_reg[k-1].ln[l].rem, nbit[l]};
                assign take[l]  = (trial[l] >= {1'b0, st_reg[k-1].dm});

                always_comb
                begin
                    ln_next[l]       = st_reg[k-1].ln[l];
                    ln_next[l].rem   = take[l] ? SW'(trial[l] - {1'b0, st_reg[k-1].dm})
                                               : SW'(trial[l]);
                    ln_next[l].q[QI] = take[l];
                end
            end

            assign st_next[k] = {ln_next[1], ln_next[0], st_reg[k-1].dm,
                                 st_reg[k-1].flags};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign ovf       = {st_reg[NS-1].ln[1].ovf, st_reg[NS-1].ln[0].ovf};
    assign neg       = {st_reg[NS-1].ln[1].neg, st_reg[NS-1].ln[0].neg};
    assign q0        = st_reg[NS-1].ln[0].q;
    assign q1        = st_reg[NS-1].ln[1].q;
    assign flags_out = st_reg[NS-1].flags;

endmodule

// File: hw/rtl/tpb_fin.sv
// Back end: sign, saturation, third weight and the output register.
module tpb_fin #(
    parameter int FRAC = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      ovf,
    input  logic [1:0]                      neg,
    input  logic [tpb_pkg::WEIGHT_BITS-1:0] q0,
    input  logic [tpb_pkg::WEIGHT_BITS-1:0] q1,
    input  tpb_pkg::tpb_flags_t             flags_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            inside_res,
    output logic                            degenerate,
    output logic signed [tpb_pkg::WEIGHT_BITS-1:0] bary_0,
    output logic signed [tpb_pkg::WEIGHT_BITS-1:0] bary_1,
    output logic signed [tpb_pkg::WEIGHT_BITS-1:0] bary_2
);

    localparam int WB = tpb_pkg::WEIGHT_BITS;
    localparam int SB = WB + 2;
    localparam int TB = WB + 3;

    localparam logic signed [SB-1:0] S_MAX = (SB'(1) <<< (WB - 1)) - SB'(1);
    localparam logic signed [SB-1:0] S_MIN = -(SB'(1) <<< (WB - 1));
    localparam logic signed [TB-1:0] T_MAX = (TB'(1) <<< (WB - 1)) - TB'(1);
    localparam logic signed [TB-1:0] T_MIN = -(TB'(1) <<< (WB - 1));
    localparam logic signed [TB-1:0] ONE   = TB'(1) <<< FRAC;

    logic en_a, en_b;
    logic va_reg, vb_reg;

    logic [WB-1:0]        q_in [2];
    logic signed [SB-1:0] mag [2];
    logic signed [SB-1:0] sval [2];
    logic signed [WB-1:0] wsat [2];

    logic signed [WB-1:0] w0_reg, w1_reg;
    tpb_pkg::tpb_flags_t  fa_reg;

    logic signed [TB-1:0] w2_wide;
    logic signed [WB-1:0] w2_sat;

    logic signed [WB-1:0] b0_reg, b1_reg, b2_reg;
    tpb_pkg::tpb_flags_t  fb_reg;

    assign en_b     = ~vb_reg | out_ready;
    assign en_a     = ~va_reg | en_b;
    assign in_ready = en_a;

    assign q_in[0] = q0;
    assign q_in[1] = q1;

    // An overflowed quotient stands for 2^32, which saturates either way.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            mag[l]  = ovf[l] ? (SB'(1) <<< WB) : SB'({1'b0, q_in[l]});
            sval[l] = neg[l] ? -mag[l] : mag[l];
            if (sval[l] > S_MAX)
                wsat[l] = WB'(S_MAX);
            else if (sval[l] < S_MIN)
                wsat[l] = WB'(S_MIN);
            else
                wsat[l] = WB'(sval[l]);
        end
    end

    always_comb
    begin
        w2_wide = ONE - TB'(w0_reg) - TB'(w1_reg);
        if (w2_wide > T_MAX)
            w2_sat = WB'(T_MAX);
        else if (w2_wide < T_MIN)
            w2_sat = WB'(T_MIN);
        else
            w2_sat = WB'(w2_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (en_a) va_reg <= in_valid;
            if (en_b) vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            w0_reg <= wsat[0];
            w1_reg <= wsat[1];
            fa_reg <= flags_in;
        end
        if (en_b)
        begin
            fb_reg <= fa_reg;
            b0_reg <= fa_reg.degen ? '0 : w0_reg;
            b1_reg <= fa_reg.degen ? '0 : w1_reg;
            b2_reg <= fa_reg.degen ? '0 : w2_sat;
        end
    end

    assign out_valid  = vb_reg;
    assign inside_res = fb_reg.hit;
    assign degenerate = fb_reg.degen;
    assign bary_0     = b0_reg;
    assign bary_1     = b1_reg;
    assign bary_2     = b2_reg;

endmodule

// File: hw/rtl/triangle_point_barycentric_core.sv
// Top level of the point-in-triangle test with barycentric weights.
//
//  Channel   Handshake             Payload
//  -------   -------------------   ------------------------------------------------
//  in        in_valid / in_ready   v0_x v0_y v1_x v1_y v2_x v2_y point_x point_y
//  out       out_valid / out_ready inside_res degenerate bary_0 bary_1 bary_2
//  cfg       cfg_we                cfg_wdata (edge tolerance)
//
// One transfer is accepted per cycle while in_ready is high. There are four front-end
// stages, 33 divider stages (an entry stage, then stages of one quotient bit each for the
// 32-bit weight width) and two back-end stages. Each stage holds its item while the next
// one is full, so a stall at the output fills the pipeline before in_ready drops. Reset
// clears the valid bits and the tolerance register.
module triangle_point_barycentric_core #(
    parameter int COORD_BITS       = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [tpb_pkg::TOL_BITS-1:0]           cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [COORD_BITS-1:0]                  v0_x,
    input  logic [COORD_BITS-1:0]                  v0_y,
    input  logic [COORD_BITS-1:0]                  v1_x,
    input  logic [COORD_BITS-1:0]                  v1_y,
    input  logic [COORD_BITS-1:0]                  v2_x,
    input  logic [COORD_BITS-1:0]                  v2_y,
    input  logic [COORD_BITS-1:0]                  point_x,
    input  logic [COORD_BITS-1:0]                  point_y,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   inside_res,
    output logic                                   degenerate,
    output logic signed [tpb_pkg::WEIGHT_BITS-1:0] bary_0,
    output logic signed [tpb_pkg::WEIGHT_BITS-1:0] bary_1,
    output logic signed [tpb_pkg::WEIGHT_BITS-1:0] bary_2
);

    localparam int SW = 2 * (COORD_BITS + 1) + 1;
    localparam int WB = tpb_pkg::WEIGHT_BITS;

    logic [tpb_pkg::TOL_BITS-1:0] tol_reg;

    logic                f_valid, f_ready;
    logic [SW-1:0]       n0_mag, n1_mag, d_mag;
    logic                neg0, neg1;
    tpb_pkg::tpb_flags_t f_flags;

    logic                d_valid, d_ready;
    logic [1:0]          d_ovf, d_neg;
    logic [WB-1:0]       d_q0, d_q1;
    tpb_pkg::tpb_flags_t d_flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg_we)
            tol_reg <= cfg_wdata;
    end

    tpb_front #(
        .CB (COORD_BITS),
        .SW (SW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .v0_x      (v0_x),
        .v0_y      (v0_y),
        .v1_x      (v1_x),
        .v1_y      (v1_y),
        .v2_x      (v2_x),
        .v2_y      (v2_y),
        .point_x   (point_x),
        .point_y   (point_y),
        .tol       (tol_reg),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .n0_mag    (n0_mag),
        .n1_mag    (n1_mag),
        .d_mag     (d_mag),
        .neg0      (neg0),
        .neg1      (neg1),
        .flags     (f_flags)
    );

    tpb_div #(
        .SW   (SW),
        .FRAC (WEIGHT_FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .n0_mag    (n0_mag),
        .n1_mag    (n1_mag),
        .d_mag     (d_mag),
        .neg0      (neg0),
        .neg1      (neg1),
        .flags_in  (f_flags),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .ovf       (d_ovf),
        .neg       (d_neg),
        .q0        (d_q0),
        .q1        (d_q1),
        .flags_out (d_flags)
    );

    tpb_fin #(
        .FRAC (WEIGHT_FRAC_BITS)
    ) u_fin (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (d_valid),
        .in_ready   (d_ready),
        .ovf        (d_ovf),
        .neg        (d_neg),
        .q0         (d_q0),
        .q1         (d_q1),
        .flags_in   (d_flags),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .inside_res (inside_res),
        .degenerate (degenerate),
        .bary_0     (bary_0),
        .bary_1     (bary_1),
        .bary_2     (bary_2)
    );

endmodule
